/* rtl/pdr_pkg.sv */
// ----------------------------------------------------------------------------
// pdr_pkg - peer discovery responder package
// Field widths, protocol constants, status and mode codes, controller types.
// ----------------------------------------------------------------------------
package pdr_pkg;

	localparam int MAC_W   = 48;
	localparam int IP_W    = 32;
	localparam int NONCE_W = 64;
	localparam int CFG_W   = 32;

	localparam logic [31:0]      DISC_MAGIC   = 32'h4d574d44;
	localparam logic [7:0]       DISC_VERSION = 8'd2;
	localparam logic [7:0]       RX_TYPE_REQ  = 8'd1;
	localparam logic [7:0]       RX_TYPE_RESP = 8'd2;
	localparam logic [1:0]       TX_TYPE_NONE = 2'd0;
	localparam logic [1:0]       TX_TYPE_REQ  = 2'd1;
	localparam logic [1:0]       TX_TYPE_RESP = 2'd2;
	localparam logic [MAC_W-1:0] MAC_BCAST    = {MAC_W{1'b1}};

	// modes
	localparam logic [1:0] MODE_RX   = 2'd0;
	localparam logic [1:0] MODE_REQ  = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_HDR    = 3'd1;
	localparam logic [2:0] ST_UNKNOWN    = 3'd2;
	localparam logic [2:0] ST_NONCE_BAD  = 3'd3;
	localparam logic [2:0] ST_LINK_DOWN  = 3'd4;
	localparam logic [2:0] ST_NO_IP      = 3'd5;
	localparam logic [2:0] ST_ZERO_NONCE = 3'd6;

	// configuration register indexes
	localparam logic CFG_NODE_ID      = 1'b0;
	localparam logic CFG_TUNNEL_COUNT = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic capture;  // latch input word
		logic read;     // read entry memory
		logic exec;     // update entry, load result
	} dp_cmd_t;

	typedef struct packed {
		logic out_free; // result register can take a word this cycle
	} dp_stat_t;

endpackage

/* rtl/pdr_if.sv */
// ----------------------------------------------------------------------------
// pdr_if - input and result channel interfaces
// Valid/ready channels carrying one item word or one result word.
// ----------------------------------------------------------------------------
interface pdr_item_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  mode;
	logic [3:0]                  port;
	logic [31:0]                 rx_magic;
	logic [7:0]                  rx_version;
	logic [7:0]                  rx_type;
	logic [pdr_pkg::MAC_W-1:0]   rx_src_mac;
	logic [pdr_pkg::IP_W-1:0]    rx_tunnel_ip;
	logic [pdr_pkg::NONCE_W-1:0] nonce;
	logic [pdr_pkg::IP_W-1:0]    own_addr;
	logic                        link_up;

	modport source (output valid, mode, port, rx_magic, rx_version, rx_type, rx_src_mac,
		rx_tunnel_ip, nonce, own_addr, link_up, input ready);
	modport sink (input valid, mode, port, rx_magic, rx_version, rx_type, rx_src_mac,
		rx_tunnel_ip, nonce, own_addr, link_up, output ready);
endinterface

interface pdr_result_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic                        peer_upd;
	logic                        tx_valid;
	logic [pdr_pkg::MAC_W-1:0]   tx_dest_mac;
	logic [1:0]                  tx_type;
	logic [pdr_pkg::IP_W-1:0]    tx_tunnel_ip;
	logic [pdr_pkg::NONCE_W-1:0] tx_nonce;
	logic                        was_resolved;
	logic                        report_unresolved;
	logic [pdr_pkg::MAC_W-1:0]   peer_mac;
	logic [pdr_pkg::IP_W-1:0]    peer_ip;

	modport source (output valid, status, peer_upd, tx_valid, tx_dest_mac, tx_type,
		tx_tunnel_ip, tx_nonce, was_resolved, report_unresolved, peer_mac, peer_ip,
		input ready);
	modport sink (input valid, status, peer_upd, tx_valid, tx_dest_mac, tx_type,
		tx_tunnel_ip, tx_nonce, was_resolved, report_unresolved, peer_mac, peer_ip,
		output ready);
endinterface

/* rtl/pdr_ctrl.sv */
// ----------------------------------------------------------------------------
// pdr_ctrl - sequencing controller
// Accept, entry read, then execute once the result register is free.
// ----------------------------------------------------------------------------
module pdr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  pdr_pkg::dp_stat_t stat,
	output pdr_pkg::dp_cmd_t  cmd
);
	import pdr_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/pdr_dp.sv */
// ----------------------------------------------------------------------------
// pdr_dp - entry table and result datapath
// Input latch, entry memory with per-entry flags, decision logic, result reg.
// ----------------------------------------------------------------------------
module pdr_dp #(
	parameter int MAX_TUNNELS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [pdr_pkg::CFG_W-1:0] cfg_data,
	input  pdr_pkg::dp_cmd_t         cmd,
	output pdr_pkg::dp_stat_t        stat,
	pdr_item_if.sink                 item,
	pdr_result_if.source             result
);
	import pdr_pkg::*;

	localparam int AW = (MAX_TUNNELS > 1) ? $clog2(MAX_TUNNELS) : 1;
	localparam int EW = MAC_W + IP_W + NONCE_W;
	localparam logic [6:0] MAX_T = 7'(MAX_TUNNELS);

	// configuration; node_id feeds no result field, so only the count is kept
	logic [4:0] tunnel_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tunnel_count_q <= '0;
		end else if (cfg_we && cfg_index == CFG_TUNNEL_COUNT) begin
			tunnel_count_q <= cfg_data[4:0];
		end
	end

	// input latch
	logic [1:0]         mode_q;
	logic [3:0]         port_q;
	logic [31:0]        magic_q;
	logic [7:0]         ver_q;
	logic [7:0]         type_q;
	logic [MAC_W-1:0]   src_q;
	logic [IP_W-1:0]    rip_q;
	logic [NONCE_W-1:0] nonce_q;
	logic [IP_W-1:0]    lip_q;
	logic               up_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= item.mode;
			port_q  <= item.port;
			magic_q <= item.rx_magic;
			ver_q   <= item.rx_version;
			type_q  <= item.rx_type;
			src_q   <= item.rx_src_mac;
			rip_q   <= item.rx_tunnel_ip;
			nonce_q <= item.nonce;
			lip_q   <= item.own_addr;
			up_q    <= item.link_up;
		end
	end

	// port lookup
	logic          known;
	logic [AW+3:0] port_wide;
	logic [AW-1:0] addr;

	assign known     = ({3'b000, port_q} < MAX_T) && ({1'b0, port_q} < tunnel_count_q);
	assign port_wide = {{AW{1'b0}}, port_q};
	assign addr      = known ? port_wide[AW-1:0] : '0;

	// entry memory: {mac, ip, nonce}; entries never written read as zero
	logic [EW-1:0]          mem [MAX_TUNNELS];
	logic [EW-1:0]          rd_q;
	logic [MAX_TUNNELS-1:0] valid_q;
	logic [MAX_TUNNELS-1:0] resolved_q;
	logic [MAX_TUNNELS-1:0] reported_q;
	logic                   we;
	logic [EW-1:0]          wdata;
	logic                   new_res, new_rep;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (cmd.read) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			resolved_q <= '0;
			reported_q <= '0;
		end else if (we) begin
			valid_q[addr]    <= 1'b1;
			resolved_q[addr] <= new_res;
			reported_q[addr] <= new_rep;
		end
	end

	// decision logic
	logic [EW-1:0]      old;
	logic [MAC_W-1:0]   old_mac;
	logic [IP_W-1:0]    old_ip;
	logic [NONCE_W-1:0] old_nonce;
	logic               old_res, old_rep;
	logic               hdr_ok, learn;
	logic [MAC_W-1:0]   w_mac;
	logic [IP_W-1:0]    w_ip;
	logic [NONCE_W-1:0] w_nonce;

	logic [2:0]         r_status;
	logic               r_changed, r_txv, r_rep;
	logic [MAC_W-1:0]   r_txd;
	logic [1:0]         r_txt;
	logic [IP_W-1:0]    r_txip;
	logic [NONCE_W-1:0] r_txn;

	assign old       = valid_q[addr] ? rd_q : '0;
	assign old_mac   = old[EW-1 -: MAC_W];
	assign old_ip    = old[NONCE_W +: IP_W];
	assign old_nonce = old[NONCE_W-1:0];
	assign old_res   = resolved_q[addr];
	assign old_rep   = reported_q[addr];

	assign hdr_ok = (magic_q == DISC_MAGIC) && (ver_q == DISC_VERSION) &&
		(type_q == RX_TYPE_REQ || type_q == RX_TYPE_RESP) &&
		(rip_q != '0) && (nonce_q != '0);
	// unicast, nonzero source address
	assign learn = (src_q != '0) && !src_q[40];

	always_comb begin
		r_status  = ST_OK;
		r_changed = 1'b0;
		r_txv     = 1'b0;
		r_txd     = '0;
		r_txt     = TX_TYPE_NONE;
		r_txip    = '0;
		r_txn     = '0;
		r_rep     = 1'b0;
		we        = 1'b0;
		w_mac     = old_mac;
		w_ip      = old_ip;
		w_nonce   = old_nonce;
		new_res   = old_res;
		new_rep   = old_rep;
		case (mode_q)
			MODE_RX: begin
				if (!hdr_ok) begin
					r_status = ST_BAD_HDR;
				end else if (!known) begin
					r_status = ST_UNKNOWN;
				end else if (type_q == RX_TYPE_RESP && old_nonce != nonce_q) begin
					r_status = ST_NONCE_BAD;
				end else begin
					if (learn) begin
						r_changed = !old_res || (old_mac != src_q) || (old_ip != rip_q);
						we        = 1'b1;
						w_mac     = src_q;
						w_ip      = rip_q;
						new_res   = 1'b1;
						new_rep   = 1'b0;
					end
					if (type_q == RX_TYPE_REQ) begin
						if (!up_q) begin
							r_status = ST_LINK_DOWN;
						end else if (lip_q == '0) begin
							r_status = ST_NO_IP;
						end else begin
							r_txv  = 1'b1;
							r_txd  = src_q;
							r_txt  = TX_TYPE_RESP;
							r_txip = lip_q;
							r_txn  = nonce_q;
						end
					end
				end
			end
			MODE_REQ: begin
				if (!known) begin
					r_status = ST_UNKNOWN;
				end else if (!up_q) begin
					r_status = ST_LINK_DOWN;
				end else if (lip_q == '0) begin
					r_status = ST_NO_IP;
				end else if (nonce_q == '0) begin
					r_status = ST_ZERO_NONCE;
				end else begin
					we      = 1'b1;
					w_nonce = nonce_q;
					r_txv   = 1'b1;
					r_txd   = MAC_BCAST;
					r_txt   = TX_TYPE_REQ;
					r_txip  = lip_q;
					r_txn   = nonce_q;
					if (!old_res && !old_rep) begin
						new_rep = 1'b1;
						r_rep   = 1'b1;
					end
				end
			end
			MODE_READ: begin
				if (!known) begin
					r_status = ST_UNKNOWN;
				end
			end
			default: begin
				r_status = ST_BAD_HDR;
			end
		endcase
		we    = we && cmd.exec;
		wdata = {w_mac, w_ip, w_nonce};
	end

	// result register
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic               changed_q, txv_q, wasr_q, rep_q;
	logic [MAC_W-1:0]   txd_q, pmac_q;
	logic [1:0]         txt_q;
	logic [IP_W-1:0]    txip_q, pip_q;
	logic [NONCE_W-1:0] txn_q;

	assign stat.out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= r_status;
			changed_q <= r_changed;
			txv_q     <= r_txv;
			txd_q     <= r_txd;
			txt_q     <= r_txt;
			txip_q    <= r_txip;
			txn_q     <= r_txn;
			wasr_q    <= known && old_res;
			rep_q     <= r_rep;
			pmac_q    <= known ? old_mac : '0;
			pip_q     <= known ? old_ip : '0;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.status            = status_q;
	assign result.peer_upd          = changed_q;
	assign result.tx_valid          = txv_q;
	assign result.tx_dest_mac       = txd_q;
	assign result.tx_type           = txt_q;
	assign result.tx_tunnel_ip      = txip_q;
	assign result.tx_nonce          = txn_q;
	assign result.was_resolved      = wasr_q;
	assign result.report_unresolved = rep_q;
	assign result.peer_mac          = pmac_q;
	assign result.peer_ip           = pip_q;

endmodule

/* rtl/peer_discovery_responder.sv */
// ----------------------------------------------------------------------------
// peer_discovery_responder - tunnel peer discovery engine
// Checks received discovery headers, learns peers, answers and issues requests.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready sink. One word per received frame (mode 0), request
//            to issue (mode 1) or entry read-back (mode 2).
//   result : valid/ready source. Exactly one result word per item word.
//   cfg    : write-only port, cfg_we/cfg_index/cfg_data; index 1 sets the
//            number of tunnel ports in use. Write only while the block is idle.
// Timing:
//   One item is in flight at a time: accept, entry-memory read, execute.
//   The result is loaded into the result register on execute, and the block
//   takes no new word before that; the single read port of the entry memory,
//   registered before the decision logic, is why the read has a state of its own.
//   The result register parts the two sides: the next word is accepted while
//   a result still waits. If the receiver stalls, the following item waits
//   in execute until the result register frees up, then input stalls too.
// Reset:
//   arst_n clears every entry (per-entry valid and flag bits), the port count
//   and the control state; the block is ready straight after reset.
// ----------------------------------------------------------------------------
module peer_discovery_responder #(
	parameter int MAX_TUNNELS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [pdr_pkg::CFG_W-1:0] cfg_data,
	pdr_item_if.sink                  item,
	pdr_result_if.source              result
);
	import pdr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     item_ready;

	// controller: sequences one item word at a time
	pdr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: entry table, checks and result register
	pdr_dp #(
		.MAX_TUNNELS (MAX_TUNNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.result    (result)
	);

	// input ready comes straight from the controller: high while idle
	assign item.ready = item_ready;

endmodule

/* verif/tb_peer_discovery_responder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peer_discovery_responder - self-checking bench for the discovery engine
// A directed table, then random phases over several port counts. Each word
// taken in is run through a local model of the peer table, and each result
// word is compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module tb_peer_discovery_responder;
	import pdr_pkg::*;

	localparam int TUNNELS     = 16;
	localparam int STALL_LIMIT = 2000; // cycles with no word moving on either side
	localparam int HOLD_CYCLES = 120;  // long receiver hold-off
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         port;
		logic [31:0]        magic;
		logic [7:0]         version;
		logic [7:0]         rtype;
		logic [MAC_W-1:0]   src_mac;
		logic [IP_W-1:0]    tun_addr;
		logic [NONCE_W-1:0] nonce;
		logic [IP_W-1:0]    own_addr;
		logic               link_up;
	} disc_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               peer_upd;
		logic               tx_valid;
		logic [MAC_W-1:0]   tx_dest_mac;
		logic [1:0]         tx_type;
		logic [IP_W-1:0]    tx_tunnel_ip;
		logic [NONCE_W-1:0] tx_nonce;
		logic               was_resolved;
		logic               report_unresolved;
		logic [MAC_W-1:0]   peer_mac;
		logic [IP_W-1:0]    peer_ip;
	} disc_result_t;

	// one row of the directed table; typed rows carry a hand-written result
	typedef struct {
		disc_item_t   it;
		bit           typed;
		disc_result_t want;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	pdr_item_if   item_ch ();
	pdr_result_if res_ch ();

	peer_discovery_responder #(
		.MAX_TUNNELS (TUNNELS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Peer table model, updated once per accepted word
	// ------------------------------------------------------------------
	logic [MAC_W-1:0]   ent_mac      [TUNNELS];
	logic [IP_W-1:0]    ent_ip       [TUNNELS];
	logic               ent_resolved [TUNNELS];
	logic [NONCE_W-1:0] ent_nonce    [TUNNELS];
	logic               ent_reported [TUNNELS];
	logic [31:0]        cfg_node_id;
	logic [4:0]         cfg_tunnels;

	function automatic disc_result_t predict_discovery(input disc_item_t it);
		disc_result_t r;
		logic         known;
		r = '0;
		known = ({1'b0, it.port} < cfg_tunnels);
		// entry contents before the word, only for a port in use
		if (known) begin
			r.was_resolved = ent_resolved[it.port];
			r.peer_mac     = ent_mac[it.port];
			r.peer_ip      = ent_ip[it.port];
		end
		case (it.mode)
		MODE_RX: begin
			// header faults win over an unknown port, which wins over nonce
			if (it.magic != DISC_MAGIC || it.version != DISC_VERSION ||
			    (it.rtype != RX_TYPE_REQ && it.rtype != RX_TYPE_RESP) ||
			    it.tun_addr == '0 || it.nonce == '0)
				r.status = ST_BAD_HDR;
			else if (!known)
				r.status = ST_UNKNOWN;
			else if (it.rtype == RX_TYPE_RESP && ent_nonce[it.port] != it.nonce)
				r.status = ST_NONCE_BAD;
			else begin
				// zero or group source is never learned
				if (it.src_mac != '0 && !it.src_mac[40]) begin
					r.peer_upd = !ent_resolved[it.port] ||
						ent_mac[it.port] != it.src_mac || ent_ip[it.port] != it.tun_addr;
					ent_mac[it.port]      = it.src_mac;
					ent_ip[it.port]       = it.tun_addr;
					ent_resolved[it.port] = 1'b1;
					ent_reported[it.port] = 1'b0;
				end
				// learning stands even when the answer cannot go out
				if (it.rtype == RX_TYPE_REQ) begin
					if (!it.link_up)
						r.status = ST_LINK_DOWN;
					else if (it.own_addr == '0)
						r.status = ST_NO_IP;
					else begin
						r.tx_valid     = 1'b1;
						r.tx_dest_mac  = it.src_mac;
						r.tx_type      = TX_TYPE_RESP;
						r.tx_tunnel_ip = it.own_addr;
						r.tx_nonce     = it.nonce;
					end
				end
			end
		end
		MODE_REQ: begin
			if (!known)
				r.status = ST_UNKNOWN;
			else if (!it.link_up)
				r.status = ST_LINK_DOWN;
			else if (it.own_addr == '0)
				r.status = ST_NO_IP;
			else if (it.nonce == '0)
				r.status = ST_ZERO_NONCE;
			else begin
				ent_nonce[it.port] = it.nonce;
				r.tx_valid     = 1'b1;
				r.tx_dest_mac  = MAC_BCAST;
				r.tx_type      = TX_TYPE_REQ;
				r.tx_tunnel_ip = it.own_addr;
				r.tx_nonce     = it.nonce;
				// first sent request of an unresolved spell is flagged once
				if (!ent_resolved[it.port] && !ent_reported[it.port]) begin
					ent_reported[it.port] = 1'b1;
					r.report_unresolved   = 1'b1;
				end
			end
		end
		MODE_READ: begin
			if (!known)
				r.status = ST_UNKNOWN;
		end
		default: begin
			r.status = ST_BAD_HDR;
		end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard
	// ------------------------------------------------------------------
	disc_result_t expected_results[$];
	bit           cur_typed;
	disc_result_t cur_want;
	int           n_words;
	int           n_results;
	int           n_mismatch;
	int           n_sent;
	int           n_reports;
	int           n_changed;
	int           st_cnt [8];
	int           idle_cycles;

	task automatic report_field(input string name, input logic [63:0] e, input logic [63:0] g);
		$display("  %s: expected %h, got %h", name, e, g);
	endtask

	task automatic check_word(input disc_result_t got, input disc_result_t want);
		if (got !== want) begin
			n_mismatch++;
			if (n_mismatch <= 10) begin
				$display("mismatch %0d on result word %0d", n_mismatch, n_results);
				if (got.status !== want.status)
					report_field("status", 64'(want.status), 64'(got.status));
				if (got.peer_upd !== want.peer_upd)
					report_field("peer_upd", 64'(want.peer_upd), 64'(got.peer_upd));
				if (got.tx_valid !== want.tx_valid)
					report_field("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
				if (got.tx_dest_mac !== want.tx_dest_mac)
					report_field("tx_dest_mac", 64'(want.tx_dest_mac), 64'(got.tx_dest_mac));
				if (got.tx_type !== want.tx_type)
					report_field("tx_type", 64'(want.tx_type), 64'(got.tx_type));
				if (got.tx_tunnel_ip !== want.tx_tunnel_ip)
					report_field("tx_tunnel_ip", 64'(want.tx_tunnel_ip), 64'(got.tx_tunnel_ip));
				if (got.tx_nonce !== want.tx_nonce)
					report_field("tx_nonce", want.tx_nonce, got.tx_nonce);
				if (got.was_resolved !== want.was_resolved)
					report_field("was_resolved", 64'(want.was_resolved), 64'(got.was_resolved));
				if (got.report_unresolved !== want.report_unresolved)
					report_field("report_unresolved", 64'(want.report_unresolved),
						64'(got.report_unresolved));
				if (got.peer_mac !== want.peer_mac)
					report_field("peer_mac", 64'(want.peer_mac), 64'(got.peer_mac));
				if (got.peer_ip !== want.peer_ip)
					report_field("peer_ip", 64'(want.peer_ip), 64'(got.peer_ip));
			end
		end
	endtask

	// Both handshakes sampled at the edge, before any of this edge's updates land.
	always @(posedge clk) begin : monitor
		disc_item_t   it;
		disc_result_t pred;
		disc_result_t got;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				it = {item_ch.mode, item_ch.port, item_ch.rx_magic, item_ch.rx_version,
					item_ch.rx_type, item_ch.rx_src_mac, item_ch.rx_tunnel_ip, item_ch.nonce,
					item_ch.own_addr, item_ch.link_up};
				pred = predict_discovery(it);
				expected_results.push_back(cur_typed ? cur_want : pred);
				n_words++;
				st_cnt[pred.status]++;
				if (pred.tx_valid)
					n_sent++;
				if (pred.report_unresolved)
					n_reports++;
				if (pred.peer_upd)
					n_changed++;
			end
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.status, res_ch.peer_upd, res_ch.tx_valid, res_ch.tx_dest_mac,
					res_ch.tx_type, res_ch.tx_tunnel_ip, res_ch.tx_nonce, res_ch.was_resolved,
					res_ch.report_unresolved, res_ch.peer_mac, res_ch.peer_ip};
				n_results++;
				if (expected_results.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch %0d: result word with nothing expected", n_mismatch);
				end else begin
					check_word(got, expected_results.pop_front());
				end
			end
		end
	end

	// Watchdog: any cycle in which neither side moves a word counts.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
				idle_cycles, expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: rotating ready pattern, plus a long hold-off every 400
	// results so the block backs up into its input.
	// ------------------------------------------------------------------
	initial begin
		int   cyc;
		int   hold_left;
		int   next_hold;
		logic go;
		res_ch.ready <= 1'b0;
		cyc = 0;
		hold_left = 0;
		next_hold = 200;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_left == 0 && n_results >= next_hold) begin
				hold_left = HOLD_CYCLES;
				next_hold += 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				go = 1'b0;
			end else begin
				case ((cyc / 64) % 6)
				0, 1:    go = 1'b1;
				2:       go = ($urandom_range(0, 1) == 0);
				3:       go = ($urandom_range(0, 3) != 0);
				4:       go = ((cyc % 4) == 0);
				default: go = ($urandom_range(0, 9) != 0);
				endcase
			end
			res_ch.ready <= go;
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	int                 burst_left;
	logic [MAC_W-1:0]   pool_mac   [4];
	logic [IP_W-1:0]    pool_ip    [4];
	logic [NONCE_W-1:0] gen_nonce  [TUNNELS]; // last request nonce offered per port
	stim_row_t          directed_tab[$];
	int                 dir_split;

	task automatic drive_fields(input disc_item_t it);
		item_ch.mode         <= it.mode;
		item_ch.port         <= it.port;
		item_ch.rx_magic     <= it.magic;
		item_ch.rx_version   <= it.version;
		item_ch.rx_type      <= it.rtype;
		item_ch.rx_src_mac   <= it.src_mac;
		item_ch.rx_tunnel_ip <= it.tun_addr;
		item_ch.nonce        <= it.nonce;
		item_ch.own_addr     <= it.own_addr;
		item_ch.link_up      <= it.link_up;
	endtask

	// Offer one word and hold it until taken; valid stays up across a burst.
	task automatic offer(input disc_item_t it, input bit typed, input disc_result_t want);
		int gap;
		item_ch.valid <= 1'b1;
		drive_fields(it);
		cur_typed <= typed;
		cur_want  <= want;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 24);
		end
	endtask

	// Stop offering and wait for every outstanding result, plus the pipe depth.
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = $urandom_range(0, 24);
	endtask

	// Both registers in turn, node id then port count; block must be idle.
	task automatic set_config(input logic [31:0] node, input logic [4:0] tc);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_NODE_ID;
		cfg_data  <= node;
		@(posedge clk);
		cfg_index <= CFG_TUNNEL_COUNT;
		cfg_data  <= {27'd0, tc};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_node_id = node;
		cfg_tunnels = tc;
	endtask

	function automatic disc_item_t mk(input logic [1:0] mode, input logic [3:0] port,
		input logic [31:0] magic, input logic [7:0] ver, input logic [7:0] typ,
		input logic [MAC_W-1:0] src, input logic [IP_W-1:0] tip,
		input logic [NONCE_W-1:0] nonce, input logic [IP_W-1:0] lip, input logic up);
		disc_item_t it;
		it = {mode, port, magic, ver, typ, src, tip, nonce, lip, up};
		return it;
	endfunction

	function automatic stim_row_t row(input disc_item_t it, input bit typed,
		input logic [2:0] st);
		stim_row_t r;
		r.it = it;
		r.typed = typed;
		r.want = '0;
		r.want.status = st;
		return r;
	endfunction

	// Mostly well-formed traffic on ports in use; a share of corrupt headers,
	// unusable source MACs, stale nonces, link-down and no-address ports.
	function automatic disc_item_t random_item();
		disc_item_t   it;
		int           pick;
		int           lim;
		logic [63:0]  raw;
		pick = $urandom_range(0, 99);
		it.mode = (pick < 45) ? MODE_RX : (pick < 80) ? MODE_REQ :
			(pick < 95) ? MODE_READ : MODE_UNUSED;
		lim = (cfg_tunnels > 5'(TUNNELS)) ? TUNNELS : int'(cfg_tunnels);
		if (lim > 0 && $urandom_range(0, 99) < 85)
			it.port = 4'($urandom_range(0, lim - 1));
		else
			it.port = 4'($urandom());
		it.magic   = DISC_MAGIC;
		it.version = DISC_VERSION;
		it.rtype   = $urandom_range(0, 1) ? RX_TYPE_REQ : RX_TYPE_RESP;
		pick = $urandom_range(0, 99);
		raw  = {$urandom(), $urandom()};
		if (pick < 80)
			it.src_mac = pool_mac[$urandom_range(0, 3)];
		else if (pick < 90)
			it.src_mac = '0;
		else
			it.src_mac = raw[MAC_W-1:0] | (48'h1 << 40);
		it.tun_addr = ($urandom_range(0, 99) < 85) ? pool_ip[$urandom_range(0, 3)] :
			32'($urandom());
		if (it.rtype == RX_TYPE_RESP && $urandom_range(0, 99) < 80)
			it.nonce = gen_nonce[it.port];
		else
			it.nonce = {$urandom(), $urandom()};
		it.own_addr = ($urandom_range(0, 9) != 0) ? 32'($urandom()) : '0;
		it.link_up  = ($urandom_range(0, 9) != 0);
		if (it.mode == MODE_REQ) begin
			if ($urandom_range(0, 19) == 0)
				it.nonce = '0;
			else
				gen_nonce[it.port] = it.nonce;
		end
		if (it.mode == MODE_RX && $urandom_range(0, 99) < 15) begin
			case ($urandom_range(0, 4))
			0:       it.magic    = 32'($urandom());
			1:       it.version  = 8'($urandom());
			2:       it.rtype    = 8'($urandom());
			3:       it.tun_addr = '0;
			default: it.nonce    = '0;
			endcase
		end
		return it;
	endfunction

	task automatic build_directed();
		logic [MAC_W-1:0] mac_a;
		logic [MAC_W-1:0] mac_max;
		mac_a   = 48'h0211_2233_4455;
		mac_max = 48'hFEFF_FFFF_FFFF; // largest unicast address
		// port count still zero after reset: every port is unknown
		directed_tab.push_back(row(mk(MODE_READ, 4'd0, '0, '0, '0, '0, '0, '0, '0, 1'b0),
			1, ST_UNKNOWN));
		directed_tab.push_back(row(mk(MODE_UNUSED, 4'd15, '1, '1, '1, '1, '1, '1, '1, 1'b1),
			1, ST_BAD_HDR));
		// header check comes before the port check
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, '0, DISC_VERSION, RX_TYPE_REQ, mac_a,
			32'h0A00_0001, 64'd7, 32'h0A00_0002, 1'b1), 1, ST_BAD_HDR));
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, DISC_MAGIC, DISC_VERSION, RX_TYPE_REQ,
			mac_a, 32'h0A00_0001, 64'd7, 32'h0A00_0002, 1'b1), 1, ST_UNKNOWN));
		// port check comes before the nonce check
		directed_tab.push_back(row(mk(MODE_RX, 4'd5, DISC_MAGIC, DISC_VERSION, RX_TYPE_RESP,
			mac_a, 32'h0A00_0001, 64'd9, 32'h0A00_0002, 1'b1), 1, ST_UNKNOWN));
		directed_tab.push_back(row(mk(MODE_REQ, 4'd0, '0, '0, '0, '0, '0, 64'd1, '0, 1'b0),
			1, ST_UNKNOWN));
		dir_split = directed_tab.size();
		// all sixteen ports in use from here on
		directed_tab.push_back(row(mk(MODE_READ, 4'd0, '0, '0, '0, '0, '0, '0, '0, 1'b1),
			1, ST_OK));
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, 32'h0, DISC_VERSION, RX_TYPE_REQ, mac_a,
			'1, '1, '1, 1'b1), 1, ST_BAD_HDR));
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, DISC_MAGIC, 8'hFF, RX_TYPE_REQ, mac_a,
			'1, '1, '1, 1'b1), 1, ST_BAD_HDR));
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, DISC_MAGIC, DISC_VERSION, 8'h00, mac_a,
			'1, '1, '1, 1'b1), 1, ST_BAD_HDR));
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, DISC_MAGIC, DISC_VERSION, 8'hFF, mac_a,
			'1, '1, '1, 1'b1), 1, ST_BAD_HDR));
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, DISC_MAGIC, DISC_VERSION, RX_TYPE_REQ,
			mac_a, '0, '1, '1, 1'b1), 1, ST_BAD_HDR));
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, DISC_MAGIC, DISC_VERSION, RX_TYPE_REQ,
			mac_a, '1, '0, '1, 1'b1), 1, ST_BAD_HDR));
		// stored nonce is still zero
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, DISC_MAGIC, DISC_VERSION, RX_TYPE_RESP,
			mac_a, '1, 64'd1, '1, 1'b1), 1, ST_NONCE_BAD));
		// request refusals in their priority order
		directed_tab.push_back(row(mk(MODE_REQ, 4'd0, '0, '0, '0, '0, '0, '1, '1, 1'b0),
			1, ST_LINK_DOWN));
		directed_tab.push_back(row(mk(MODE_REQ, 4'd0, '0, '0, '0, '0, '0, '1, '0, 1'b1),
			1, ST_NO_IP));
		directed_tab.push_back(row(mk(MODE_REQ, 4'd0, '0, '0, '0, '0, '0, '0, '1, 1'b1),
			1, ST_ZERO_NONCE));
		// first request reports, the second does not
		directed_tab.push_back(row(mk(MODE_REQ, 4'd0, '0, '0, '0, '0, '0, '1, '1, 1'b1),
			0, ST_OK));
		directed_tab.push_back(row(mk(MODE_REQ, 4'd0, '0, '0, '0, '0, '0, 64'd1, 32'd1, 1'b1),
			0, ST_OK));
		// matching response learns; the old nonce is then stale
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, DISC_MAGIC, DISC_VERSION, RX_TYPE_RESP,
			mac_a, '1, 64'd1, '1, 1'b1), 0, ST_OK));
		directed_tab.push_back(row(mk(MODE_RX, 4'd0, DISC_MAGIC, DISC_VERSION, RX_TYPE_RESP,
			mac_a, '1, '1, '1, 1'b1), 0, ST_OK));
		// zero and group sources are not learned; only the zero one is answered
		directed_tab.push_back(row(mk(MODE_RX, 4'd15, DISC_MAGIC, DISC_VERSION, RX_TYPE_REQ,
			'0, 32'h0A00_0001, '1, 32'hC0A8_0001, 1'b1), 0, ST_OK));
		directed_tab.push_back(row(mk(MODE_RX, 4'd15, DISC_MAGIC, DISC_VERSION, RX_TYPE_REQ,
			MAC_BCAST, 32'h0A00_0001, '1, 32'hC0A8_0001, 1'b0), 0, ST_OK));
		// learns though the answer cannot go, then learns again unchanged
		directed_tab.push_back(row(mk(MODE_RX, 4'd15, DISC_MAGIC, DISC_VERSION, RX_TYPE_REQ,
			mac_max, 32'h0A00_0001, 64'd3, '0, 1'b1), 0, ST_OK));
		directed_tab.push_back(row(mk(MODE_RX, 4'd15, DISC_MAGIC, DISC_VERSION, RX_TYPE_REQ,
			mac_max, 32'h0A00_0001, 64'd3, 32'hC0A8_0001, 1'b1), 0, ST_OK));
		directed_tab.push_back(row(mk(MODE_READ, 4'd15, '0, '0, '0, '0, '0, '0, '0, 1'b1),
			0, ST_OK));
		directed_tab.push_back(row(mk(MODE_UNUSED, 4'd3, '0, '0, '0, '0, '0, '0, '0, 1'b0),
			1, ST_BAD_HDR));
		// resolved entry: request goes out without a report
		directed_tab.push_back(row(mk(MODE_REQ, 4'd15, '0, '0, '0, '0, '0, 64'd5,
			32'hC0A8_0001, 1'b1), 0, ST_OK));
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int          ph_tc  [5];
		int          ph_len [5];
		logic [31:0] node;
		disc_item_t  idle_word;
		ph_tc     = '{16, 1, 0, 9, 16};
		ph_len    = '{400, 150, 60, 300, 300};
		idle_word = '0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_NODE_ID;
		cfg_data  <= '0;
		item_ch.valid <= 1'b0;
		drive_fields(idle_word);
		cur_typed <= 1'b0;
		cur_want  <= '0;
		for (int i = 0; i < TUNNELS; i++) begin
			ent_mac[i]      = '0;
			ent_ip[i]       = '0;
			ent_resolved[i] = 1'b0;
			ent_nonce[i]    = '0;
			ent_reported[i] = 1'b0;
			gen_nonce[i]    = '0;
		end
		for (int i = 0; i < 4; i++) begin
			pool_mac[i] = (48'({$urandom(), $urandom()}) & ~(48'h1 << 40)) | 48'h1;
			pool_ip[i]  = 32'($urandom()) | 32'h1;
		end
		cfg_node_id = '0;
		cfg_tunnels = '0;
		n_words = 0;
		n_results = 0;
		n_mismatch = 0;
		n_sent = 0;
		n_reports = 0;
		n_changed = 0;
		idle_cycles = 0;
		foreach (st_cnt[i])
			st_cnt[i] = 0;
		burst_left = $urandom_range(0, 24);
		build_directed();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; registers change once the reset-state rows are done
		for (int i = 0; i < directed_tab.size(); i++) begin
			if (i == dir_split) begin
				drain();
				set_config('1, 5'd16);
			end
			offer(directed_tab[i].it, directed_tab[i].typed, directed_tab[i].want);
		end

		// random phases over port counts, node id at both ends and between
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			node = (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : 32'($urandom());
			set_config(node, 5'(ph_tc[ph]));
			for (int k = 0; k < ph_len[ph]; k++) begin
				offer(random_item(), 1'b0, '0);
				// now and then the sender waits for the block to empty
				if ((k % 137) == 136)
					drain();
			end
		end
		drain();
		repeat (8) @(posedge clk);

		$display("%0d words, port counts 0/1/9/16: %0d sent, %0d reports, %0d changes",
			n_words, n_sent, n_reports, n_changed);
		$display("status ok %0d hdr %0d port %0d nonce %0d link %0d ip %0d zero %0d",
			st_cnt[ST_OK], st_cnt[ST_BAD_HDR], st_cnt[ST_UNKNOWN], st_cnt[ST_NONCE_BAD],
			st_cnt[ST_LINK_DOWN], st_cnt[ST_NO_IP], st_cnt[ST_ZERO_NONCE]);
		if (n_mismatch == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results never arrived", n_mismatch,
				expected_results.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
